@@ sv/dmc_delta_bit_encoder_core_defines.svh @@
// Assertion macros shared by the delta bit encoder checker.
`ifndef DMC_DELTA_BIT_ENCODER_CORE_DEFINES_SVH
`define DMC_DELTA_BIT_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define DMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmc assertion failed");

// Next-cycle implication, disabled while reset is low.
`define DMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmc assertion failed");

`endif

@@ sv/dmc_pkg.sv @@
// Package: constants, state type and control/status structs of the delta bit encoder.
package dmc_pkg;

    localparam int BLOCK_BYTES    = 64;
    localparam int STEP_FRAC_BITS = 16;

    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 20;
    localparam int BYTE_W     = 8;
    localparam int BLOCK_BITS = BLOCK_BYTES * 8;
    localparam int CNT_W      = $clog2(BLOCK_BITS);
    localparam int POS_W      = ((STEP_FRAC_BITS > STEP_W) ? STEP_FRAC_BITS : STEP_W) + 1;

    localparam logic [POS_W-1:0]  ONE_POS    = POS_W'(1) << STEP_FRAC_BITS;
    localparam logic [STEP_W-1:0] MIN_STEP   = STEP_W'(ONE_POS >> 6);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(ONE_POS);
    localparam logic [CNT_W-1:0]  BYTE_MASK  = ~CNT_W'(7);
    localparam logic [CNT_W:0]    BLOCK_END  = (CNT_W+1)'(BLOCK_BITS);
    localparam logic [CNT_W:0]    BYTE_BITS  = (CNT_W+1)'(8);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_DRAIN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic bit_en;
        logic frame_end;
        logic hold_out;
        logic flush_byte;
    } t_dp_cmd;

    typedef struct packed {
        logic pos_done;
        logic byte_full;
        logic hold_valid;
        logic out_free;
        logic blk_zero;
        logic flush_last;
    } t_dp_sts;

endpackage

@@ sv/dmc_ctrl.sv @@
// Controller: sequences bit generation, frame end, held-byte drain and flush.
module dmc_ctrl import dmc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_finish,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_finish) begin
                        n_state = ST_FLUSH;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_BITS;
                    end
                end
            end
            ST_BITS: begin
                if (i_sts.pos_done) begin
                    o_cmd.frame_end = 1'b1;
                    n_state         = ST_DRAIN;
                end else if (!(i_sts.byte_full && i_sts.hold_valid && !i_sts.out_free)) begin
                    o_cmd.bit_en = 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.hold_valid) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.hold_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (i_sts.blk_zero) begin
                    o_cmd.clear = 1'b1;
                    n_state     = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush_byte = 1'b1;
                    if (i_sts.flush_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/dmc_dpath.sv @@
// Datapath: position accumulator, delta bit, byte packing, held byte and output register.
module dmc_dpath import dmc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_cfg_we,
    input  logic [STEP_W-1:0]          i_cfg_wdata,
    input  logic                       i_out_ready,
    output t_dp_sts                    o_sts,
    output logic                       o_out_valid,
    output logic [BYTE_W-1:0]          o_out_byte,
    output logic                       o_out_last,
    output logic                       o_out_end
);

    logic [STEP_W-1:0]          r_step;
    logic signed [SAMPLE_W-1:0] r_cur;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic                       r_last_bit;
    logic [POS_W-1:0]           r_pos;
    logic [CNT_W-1:0]           r_cnt;
    logic [BYTE_W-1:0]          r_shift;
    logic                       r_hold_vld;
    logic [BYTE_W-1:0]          r_hold;
    logic                       r_out_vld;
    logic [BYTE_W-1:0]          r_out_byte;
    logic                       r_out_last;
    logic                       r_out_end;

    logic [STEP_W-1:0] step_eff;
    logic              bit_val;
    logic [BYTE_W-1:0] shift_new;
    logic [CNT_W:0]    cnt_inc;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W:0]    flush_sum;
    logic              flush_last;
    logic              byte_done;
    logic              push_bit;

    always_comb begin
        step_eff = (r_step < MIN_STEP) ? MIN_STEP : r_step;
        if (r_cur < r_prev) begin
            bit_val = 1'b0;
        end else if (r_cur > r_prev) begin
            bit_val = 1'b1;
        end else begin
            bit_val = ~r_last_bit;
        end
        shift_new  = r_shift | (BYTE_W'(bit_val) << r_cnt[2:0]);
        cnt_inc    = {1'b0, r_cnt} + (CNT_W+1)'(1);
        cnt_next   = (cnt_inc == BLOCK_END) ? '0 : cnt_inc[CNT_W-1:0];
        flush_sum  = {1'b0, r_cnt & BYTE_MASK} + BYTE_BITS;
        flush_last = (flush_sum == BLOCK_END);
        byte_done  = i_cmd.bit_en && (&r_cnt[2:0]);
        push_bit   = byte_done && r_hold_vld;
    end

    assign o_sts.pos_done   = (r_pos >= ONE_POS);
    assign o_sts.byte_full  = &r_cnt[2:0];
    assign o_sts.hold_valid = r_hold_vld;
    assign o_sts.out_free   = !r_out_vld || i_out_ready;
    assign o_sts.blk_zero   = (r_cnt == '0);
    assign o_sts.flush_last = flush_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= STEP_RESET;
            r_prev     <= '0;
            r_last_bit <= 1'b0;
            r_pos      <= '0;
            r_cnt      <= '0;
            r_shift    <= '0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
            if (i_cmd.bit_en) begin
                r_prev     <= r_cur;
                r_last_bit <= bit_val;
                r_pos      <= r_pos + POS_W'(step_eff);
                r_cnt      <= cnt_next;
                r_shift    <= byte_done ? '0 : shift_new;
                if (byte_done) begin
                    r_hold_vld <= 1'b1;
                end
            end
            if (i_cmd.frame_end) begin
                r_pos <= r_pos - ONE_POS;
            end
            if (i_cmd.hold_out) begin
                r_hold_vld <= 1'b0;
            end
            if (i_cmd.flush_byte) begin
                r_cnt   <= flush_last ? '0 : flush_sum[CNT_W-1:0];
                r_shift <= '0;
            end
            if (i_cmd.clear) begin
                r_prev     <= '0;
                r_last_bit <= 1'b0;
                r_pos      <= '0;
                r_cnt      <= '0;
                r_shift    <= '0;
            end
            if (push_bit || i_cmd.hold_out || i_cmd.flush_byte) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur <= i_sample;
        end
        if (byte_done) begin
            r_hold <= shift_new;
        end
        if (push_bit) begin
            r_out_byte <= r_hold;
            r_out_last <= 1'b0;
            r_out_end  <= 1'b0;
        end else if (i_cmd.hold_out) begin
            r_out_byte <= r_hold;
            r_out_last <= 1'b1;
            r_out_end  <= 1'b0;
        end else if (i_cmd.flush_byte) begin
            r_out_byte <= r_shift;
            r_out_last <= flush_last;
            r_out_end  <= flush_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_out_end   = r_out_end;

endmodule

@@ sv/dmc_delta_bit_encoder_core.sv @@
// Top level of the one-bit delta modulation encoder with fixed-point resampling.
// Input stream: s_axis_tdata carries a signed 16-bit audio frame, s_axis_tuser[0]
// marks a finish item (pad to a 64-byte boundary, flush, clear state).
// Output stream: m_axis_tdata is a packed byte of delta bits (first bit in bit 0),
// m_axis_tlast marks the last byte an input item causes, m_axis_tuser[0] marks
// the final padded byte of the stream.
// i_cfg_we/i_cfg_wdata write the Q4.16 step; write it only while the block is idle.
// A sample item is accepted, then yields one output bit per cycle (up to 64, set by
// the step against the 1.0 frame boundary) unless bit generation waits, then ends the
// frame and releases the held byte, if any. The shared bit step is the loop.
// The newest finished byte is held back until the frame ends so that tlast can be
// set on it; older bytes go to the output register as soon as it is free.
// A finish item is accepted, then emits one padded byte per cycle while the output register
// is free (up to 64), or just clears the state when no bits are pending.
// When the receiver stalls, the output register keeps its byte and bit generation waits once
// a byte completes with the held byte and the output register both full; nothing is dropped.
// Reset clears the FSM, counters and valid flags and sets the step to 1.0 frame per bit.
module dmc_delta_bit_encoder_core import dmc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,   // [15:0] sample
    input  logic [0:0]          s_axis_tuser,   // [0] finish
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [7:0] data_byte
    output logic                m_axis_tlast,
    output logic [0:0]          m_axis_tuser,   // [0] stream_end
    input  logic                i_cfg_we,
    input  logic [STEP_W-1:0]   i_cfg_wdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    dmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_finish   (s_axis_tuser[0]),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    dmc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sample    ($signed(s_axis_tdata)),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (m_axis_tready),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_end   (m_axis_tuser[0])
    );

endmodule

@@ sv/dmc_checker.sv @@
// Port-level checker for the delta bit encoder, bound to the top level.
`include "dmc_delta_bit_encoder_core_defines.svh"

module dmc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [7:0]        m_axis_tdata,
    input logic              m_axis_tlast,
    input logic [0:0]        m_axis_tuser,
    input logic              i_cfg_we
);

    // stream end byte always closes its run
    `DMC_ASSERT_IMP(a_end_has_last, i_clk, i_rst_n,
                    m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)

    // every accepted item leaves the block busy in the next cycle
    `DMC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n,
                    s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // stalled output holds
    `DMC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
                    && $stable(m_axis_tuser))

    // step is only written while idle
    `DMC_ASSERT_IMP(a_cfg_idle, i_clk, i_rst_n, i_cfg_we, s_axis_tready)

endmodule

bind dmc_delta_bit_encoder_core dmc_checker u_dmc_checker (.*);

@@ sim/tb_dmc_delta_bit_encoder_core.sv @@
// Testbench for the delta bit encoder core: directed and random streams checked by a predictor.
module tb_dmc_delta_bit_encoder_core;
    import dmc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 80;
    localparam int IDLE_PCT      = 12;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 37;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_run;
        logic       stream_end;
    } t_enc_byte;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata;   // [15:0] sample
    logic [0:0]          s_axis_tuser;   // [0] finish
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [7:0]          m_axis_tdata;   // [7:0] data_byte
    logic                m_axis_tlast;
    logic [0:0]          m_axis_tuser;   // [0] stream_end
    logic                i_cfg_we;
    logic [STEP_W-1:0]   i_cfg_wdata;

    // encoder model state
    logic [STEP_W-1:0]   step_val;
    logic signed [15:0]  prev_level;
    logic                prev_bit;
    logic [POS_W-1:0]    pos_acc;
    logic [CNT_W-1:0]    bit_count;
    logic [7:0]          byte_acc;
    t_enc_byte           held_byte;
    logic                held_valid;

    t_enc_byte           enc_byte_q[$];
    int                  mismatch_cnt = 0;
    logic                no_stall = 1'b0;
    logic signed [15:0]  last_sent = '0;

    dmc_delta_bit_encoder_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= no_stall || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    // result checker
    always @(posedge i_clk) begin : check_results
        t_enc_byte want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (enc_byte_q.size() == 0) begin
                $error("unexpected byte %0h", m_axis_tdata);
                mismatch_cnt++;
            end else begin
                want = enc_byte_q.pop_front();
                if (m_axis_tdata !== want.data_byte) begin
                    $error("data_byte expected %0h actual %0h", want.data_byte, m_axis_tdata);
                    mismatch_cnt++;
                end
                if (m_axis_tlast !== want.last_of_run) begin
                    $error("last_of_run expected %0b actual %0b", want.last_of_run,
                           m_axis_tlast);
                    mismatch_cnt++;
                end
                if (m_axis_tuser[0] !== want.stream_end) begin
                    $error("stream_end expected %0b actual %0b", want.stream_end,
                           m_axis_tuser[0]);
                    mismatch_cnt++;
                end
            end
        end
    end

    task automatic clear_encoder();
        prev_level = '0;
        prev_bit   = 1'b0;
        pos_acc    = '0;
        bit_count  = '0;
        byte_acc   = '0;
    endtask

    // newest byte is held so tlast can be set on it at the end of the item
    task automatic push_bit(input logic b);
        byte_acc[bit_count[2:0]] = b;
        bit_count = (bit_count == CNT_W'(BLOCK_BITS - 1)) ? '0 : bit_count + 1'b1;
        if (bit_count[2:0] == 3'd0) begin
            if (held_valid)
                enc_byte_q.push_back(held_byte);
            held_byte  = '{data_byte: byte_acc, last_of_run: 1'b0, stream_end: 1'b0};
            held_valid = 1'b1;
            byte_acc   = '0;
        end
    endtask

    task automatic encode_item(input logic signed [15:0] smp, input logic fin);
        logic [STEP_W-1:0] eff_step;
        logic              b;
        held_valid = 1'b0;
        if (fin) begin
            while (bit_count != '0)
                push_bit(1'b0);
            if (held_valid)
                held_byte.stream_end = 1'b1;
            clear_encoder();
        end else begin
            eff_step = (step_val < MIN_STEP) ? MIN_STEP : step_val;
            while (pos_acc < ONE_POS) begin
                if (smp < prev_level)
                    b = 1'b0;
                else if (smp > prev_level)
                    b = 1'b1;
                else
                    b = ~prev_bit;
                prev_bit   = b;
                prev_level = smp;
                push_bit(b);
                pos_acc = pos_acc + POS_W'(eff_step);
            end
            pos_acc = pos_acc - ONE_POS;
        end
        if (held_valid) begin
            held_byte.last_of_run = 1'b1;
            enc_byte_q.push_back(held_byte);
        end
    endtask

    task automatic send_item(input logic signed [15:0] smp, input logic fin);
        if (!no_stall) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= fin ? 16'($urandom) : smp;
        s_axis_tuser  <= fin;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        encode_item(smp, fin);
        if (!fin)
            last_sent = smp;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (enc_byte_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] val);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        step_val = val;
    endtask

    task automatic test_empty_finish();
        send_item('0, 1'b1);
    endtask

    task automatic test_unit_step_extremes();
        send_item(16'sd0, 1'b0);
        send_item(16'sd0, 1'b0);
        send_item(16'sh7FFF, 1'b0);
        send_item(-16'sh8000, 1'b0);
        send_item(-16'sh8000, 1'b0);
        send_item(16'sh7FFF, 1'b0);
        send_item(-16'sd1, 1'b0);
        send_item(16'sd1, 1'b0);
        send_item('0, 1'b1);
    endtask

    // zero step is raised to the minimum; eight full frames fill the block exactly
    task automatic test_min_step_full_block();
        write_step('0);
        send_item(16'sd5, 1'b0);
        send_item(16'sd5, 1'b0);
        send_item(-16'sd3, 1'b0);
        send_item(16'sh7FFF, 1'b0);
        write_step(MIN_STEP);
        send_item(-16'sh8000, 1'b0);
        send_item(16'sd0, 1'b0);
        send_item(16'sd0, 1'b0);
        send_item(16'sh1234, 1'b0);
        send_item('0, 1'b1);
    endtask

    task automatic test_max_step();
        write_step('1);
        send_item(16'sd100, 1'b0);
        send_item(16'sd100, 1'b0);
        send_item(-16'sd5, 1'b0);
        send_item(16'sd7, 1'b0);
        send_item('0, 1'b1);
    endtask

    function automatic logic signed [15:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return 16'($urandom);
        else if (sel < 70)
            return last_sent + 16'(int'($urandom_range(0, 2)) - 1);
        else if (sel < 90)
            return last_sent;
        else
            return $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
    endfunction

    task automatic test_random_phases();
        logic [STEP_W-1:0] step;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: step = MIN_STEP;
                1: step = STEP_RESET;
                2: step = MIN_STEP - 1'b1;
                3: step = '1;
                4: step = '0;
                default: begin
                    if ($urandom_range(0, 99) < 70)
                        step = STEP_W'($urandom_range(1024, 131072));
                    else
                        step = STEP_W'($urandom_range(0, 20'hFFFFF));
                end
            endcase
            write_step(step);
            no_stall = (ph == 6);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 2)
                    wait_drained();
                if ($urandom_range(0, 99) < 4)
                    send_item('0, 1'b1);
                else
                    send_item(pick_sample(), 1'b0);
            end
            no_stall = 1'b0;
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        step_val = STEP_RESET;
        clear_encoder();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_finish();
        test_unit_step_extremes();
        test_min_step_full_block();
        test_max_step();
        test_random_phases();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && enc_byte_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
